[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, off while reset is low
`define RFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// overlapping implication built on the macro above
`define RFB_ASSERT_IMP(lbl, ante, cons, msg) \
  `RFB_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/rfb_pkg.sv]
// shared types, constants and register codes of the text blitter
package rfb_pkg;

  localparam int FRAME_WIDTH_DEF  = 64;
  localparam int FRAME_HEIGHT_DEF = 64;

  // signed coordinate width, holds cursor plus scaled glyph offset plus block step
  localparam int COORD_W = 18;

  localparam logic [15:0] TEXT_COLOR_RST = 16'hFFFF;
  localparam logic [3:0]  TEXT_SCALE_RST = 4'd1;

  // register indexes, one 32-bit word each
  localparam logic REG_TEXT_COLOR = 1'b0;
  localparam logic REG_TEXT_SCALE = 1'b1;

  typedef enum logic [2:0] {
    ACT_CURSOR = 3'd0,
    ACT_PIXEL  = 3'd1,
    ACT_FILL   = 3'd2,
    ACT_HEADER = 3'd3,
    ACT_BITMAP = 3'd4,
    ACT_READ   = 3'd5
  } action_e;

  typedef struct packed {
    logic [15:0] color;
    logic [3:0]  scale;
  } text_cfg_t;

endpackage

[rtl/rfb_ram.sv]
// generic single-clock ram, one write port and one registered read port
module rfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rfb_ctrl.sv]
// item sequencer: cursor, glyph walk, block painter, fill sweep and read-back
module rfb_ctrl #(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 64,
  localparam int AddrW = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rfb_pkg::text_cfg_t      cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              action_i,
  input  logic signed [15:0]      pos_x_i,
  input  logic signed [15:0]      pos_y_i,
  input  logic [15:0]             color_i,
  input  logic [7:0]              glyph_cols_i,
  input  logic [7:0]              glyph_rows_i,
  input  logic signed [7:0]       offset_x_i,
  input  logic signed [7:0]       offset_y_i,
  input  logic [7:0]              advance_i,
  input  logic [7:0]              bitmap_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o,
  output logic                    in_range_o,
  output logic                    mem_we_o,
  output logic [AddrW-1:0]        mem_waddr_o,
  output logic [15:0]             mem_wdata_o,
  output logic [AddrW-1:0]        mem_raddr_o,
  input  logic [15:0]             mem_rdata_i
);
  import rfb_pkg::*;

  localparam int XW    = $clog2(FRAME_WIDTH);
  localparam int YW    = $clog2(FRAME_HEIGHT);
  localparam int Depth = FRAME_WIDTH * FRAME_HEIGHT;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [AddrW-1:0] WidthA   = AddrW'(FRAME_WIDTH);
  localparam logic signed [COORD_W-1:0] XLim = COORD_W'(FRAME_WIDTH);
  localparam logic signed [COORD_W-1:0] YLim = COORD_W'(FRAME_HEIGHT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_PAINT,
    ST_STEP,
    ST_FILL,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [15:0]        cursor_x;
    logic [15:0]        cursor_y;
    logic [7:0]         cols;
    logic [7:0]         rows;
    logic [7:0]         dx;
    logic [7:0]         dy;
    logic [7:0]         adv;
    logic [7:0]         col_pos;
    logic [7:0]         row_pos;
    logic               active;
    logic [7:0]         bits;
    logic [2:0]         bit_idx;
    logic [COORD_W-1:0] org_x;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [3:0]         i;
    logic [3:0]         j;
    logic [3:0]         lim;
    logic               glyph;
    logic [15:0]        color;
    logic [AddrW-1:0]   fill_addr;
    logic               out_valid;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               in_range;
  } regs_t;

  state_e state_q, state_d;
  regs_t  r_q, r_d;

  logic                      pix_inside;
  logic [AddrW-1:0]          pix_addr;
  logic signed [9:0]         sum_x, sum_y;
  logic signed [4:0]         scl;
  logic signed [14:0]        prod_x, prod_y;
  logic signed [COORD_W-1:0] blk_x, blk_y;
  logic [7:0]                adv_src;
  logic [15:0]               adv_sum;
  logic [7:0]                col_n, row_n;

  // pixel at the current walk position, clipped and mapped to an address
  assign pix_inside = ($signed(r_q.cur_x) >= 0) && ($signed(r_q.cur_x) < XLim) &&
                      ($signed(r_q.cur_y) >= 0) && ($signed(r_q.cur_y) < YLim);
  assign pix_addr   = AddrW'(r_q.cur_y[YW-1:0]) * WidthA + AddrW'(r_q.cur_x[XW-1:0]);

  // top-left corner of the scaled block for the current glyph bit
  assign sum_x  = $signed({{2{r_q.dx[7]}}, r_q.dx}) + $signed({2'b00, r_q.col_pos});
  assign sum_y  = $signed({{2{r_q.dy[7]}}, r_q.dy}) + $signed({2'b00, r_q.row_pos});
  assign scl    = $signed({1'b0, cfg_i.scale});
  assign prod_x = sum_x * scl;
  assign prod_y = sum_y * scl;
  assign blk_x  = $signed({{2{r_q.cursor_x[15]}}, r_q.cursor_x}) + COORD_W'(prod_x);
  assign blk_y  = $signed({{2{r_q.cursor_y[15]}}, r_q.cursor_y}) + COORD_W'(prod_y);

  // cursor advance, shared by empty headers and the end of a glyph
  assign adv_src = (state_q == ST_IDLE) ? advance_i : r_q.adv;
  assign adv_sum = r_q.cursor_x + 16'(adv_src) * 16'(cfg_i.scale);

  assign col_n = r_q.col_pos + 8'd1;
  assign row_n = r_q.row_pos + 8'd1;

  always_comb begin
    state_d = state_q;
    r_d     = r_q;

    if (r_q.out_valid && out_ready_i) begin
      r_d.out_valid = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (action_e'(action_i))
            ACT_CURSOR: begin
              r_d.cursor_x = pos_x_i;
              r_d.cursor_y = pos_y_i;
            end
            ACT_PIXEL: begin
              r_d.cur_x = COORD_W'(pos_x_i);
              r_d.cur_y = COORD_W'(pos_y_i);
              r_d.i     = '0;
              r_d.j     = '0;
              r_d.lim   = '0;
              r_d.glyph = 1'b0;
              r_d.color = color_i;
              state_d   = ST_PAINT;
            end
            ACT_FILL: begin
              r_d.color     = color_i;
              r_d.fill_addr = '0;
              state_d       = ST_FILL;
            end
            ACT_HEADER: begin
              r_d.cols    = glyph_cols_i;
              r_d.rows    = glyph_rows_i;
              r_d.dx      = offset_x_i;
              r_d.dy      = offset_y_i;
              r_d.adv     = advance_i;
              r_d.col_pos = '0;
              r_d.row_pos = '0;
              if ((glyph_cols_i == 8'd0) || (glyph_rows_i == 8'd0)) begin
                r_d.active   = 1'b0;
                r_d.cursor_x = adv_sum;
              end else begin
                r_d.active = 1'b1;
              end
            end
            ACT_BITMAP: begin
              r_d.bits    = bitmap_byte_i;
              r_d.bit_idx = 3'd7;
              state_d     = ST_BIT;
            end
            ACT_READ: begin
              r_d.cur_x = COORD_W'(pos_x_i);
              r_d.cur_y = COORD_W'(pos_y_i);
              state_d   = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_BIT: begin
        if (!r_q.active) begin
          state_d = ST_IDLE;
        end else if (r_q.bits[r_q.bit_idx] && (cfg_i.scale != 4'd0)) begin
          r_d.org_x = blk_x;
          r_d.cur_x = blk_x;
          r_d.cur_y = blk_y;
          r_d.i     = '0;
          r_d.j     = '0;
          r_d.lim   = cfg_i.scale - 4'd1;
          r_d.glyph = 1'b1;
          r_d.color = cfg_i.color;
          state_d   = ST_PAINT;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_PAINT: begin
        if (r_q.i == r_q.lim) begin
          if (r_q.j == r_q.lim) begin
            state_d = r_q.glyph ? ST_STEP : ST_IDLE;
          end else begin
            r_d.i     = '0;
            r_d.j     = r_q.j + 4'd1;
            r_d.cur_x = r_q.org_x;
            r_d.cur_y = r_q.cur_y + COORD_W'(1);
          end
        end else begin
          r_d.i     = r_q.i + 4'd1;
          r_d.cur_x = r_q.cur_x + COORD_W'(1);
        end
      end
      ST_STEP: begin
        if (col_n >= r_q.cols) begin
          r_d.col_pos = '0;
          r_d.row_pos = row_n;
          if (row_n >= r_q.rows) begin
            r_d.cursor_x = adv_sum;
            r_d.active   = 1'b0;
          end
        end else begin
          r_d.col_pos = col_n;
        end
        if (r_q.bit_idx == 3'd0) begin
          state_d = ST_IDLE;
        end else begin
          r_d.bit_idx = r_q.bit_idx - 3'd1;
          state_d     = ST_BIT;
        end
      end
      ST_FILL: begin
        r_d.fill_addr = r_q.fill_addr + AddrW'(1);
        if (r_q.fill_addr == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!r_q.out_valid || out_ready_i) begin
          r_d.out_valid = 1'b1;
          r_d.in_range  = pix_inside;
          if (pix_inside) begin
            r_d.red   = {mem_rdata_i[15:11], 3'b000};
            r_d.green = {mem_rdata_i[10:5], 2'b00};
            r_d.blue  = {mem_rdata_i[4:0], 3'b000};
          end else begin
            r_d.red   = '0;
            r_d.green = '0;
            r_d.blue  = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = r_q.out_valid;
  assign red_o       = r_q.red;
  assign green_o     = r_q.green;
  assign blue_o      = r_q.blue;
  assign in_range_o  = r_q.in_range;

  assign mem_we_o    = (state_q == ST_FILL) || ((state_q == ST_PAINT) && pix_inside);
  assign mem_waddr_o = (state_q == ST_FILL) ? r_q.fill_addr : pix_addr;
  assign mem_wdata_o = r_q.color;
  assign mem_raddr_o = pix_addr;

endmodule

[rtl/rgb565_framebuffer_text_blitter.sv]
// top level of the rgb565 frame store with glyph blitter and register port
// RGB565 frame store of FRAME_WIDTH x FRAME_HEIGHT pixels (64x64 by default) held
// in one memory with one write port and a registered read port, fed by one item
// beat at a time. Items are taken one at a time; a read may also wait for an
// earlier result beat to be taken, and a fill sweeps every frame address in
// turn. For a bitmap byte, each bit is tested in one control state and stepped
// past in another, and a set bit first paints its s x s block, s being
// text_scale, with one memory write per pixel, so the single frame memory write
// port sets the pace. Bits after the glyph ends stop the walk early. Only reads
// return a result beat (red, green, blue widened from 565, plus in_range); a
// read outside the frame returns zeros with in_range low. The result sits in an
// output register, so further items are still taken while it waits. The frame
// memory has no reset: a pixel must be written, or filled, before it is read.
// Registers: text_color at 0x0 (reset 0xFFFF) and text_scale at 0x4 (reset 1);
// both are to be written only while idle, by the user; the block does not enforce it.
`include "assert_macros.svh"

module rgb565_framebuffer_text_blitter #(
  parameter int FRAME_WIDTH  = rfb_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rfb_pkg::FRAME_HEIGHT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // item channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         action_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [15:0]        color_i,
  input  logic [7:0]         glyph_cols_i,
  input  logic [7:0]         glyph_rows_i,
  input  logic signed [7:0]  offset_x_i,
  input  logic signed [7:0]  offset_y_i,
  input  logic [7:0]         advance_i,
  input  logic [7:0]         bitmap_byte_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic               in_range_o
);
  import rfb_pkg::*;

  localparam int Depth = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AddrW = $clog2(Depth);

  text_cfg_t cfg_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [15:0]      mem_rdata;

  logic cfg_wr;

  // register writes land on the access phase; no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color <= TEXT_COLOR_RST;
      cfg_q.scale <= TEXT_SCALE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TEXT_COLOR: cfg_q.color <= pwdata[15:0];
        REG_TEXT_SCALE: cfg_q.scale <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // read-back, zero-padded to the word
  always_comb begin
    unique case (paddr[2])
      REG_TEXT_COLOR: prdata = {16'h0000, cfg_q.color};
      REG_TEXT_SCALE: prdata = {28'h0000000, cfg_q.scale};
      default:        prdata = '0;
    endcase
  end

  // sequencer: decodes items, walks glyph bits and blocks, sweeps fills
  rfb_ctrl #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .color_i       (color_i),
    .glyph_cols_i  (glyph_cols_i),
    .glyph_rows_i  (glyph_rows_i),
    .offset_x_i    (offset_x_i),
    .offset_y_i    (offset_y_i),
    .advance_i     (advance_i),
    .bitmap_byte_i (bitmap_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .in_range_o    (in_range_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  // frame memory, row-major, one rgb565 word per pixel
  rfb_ram #(
    .WIDTH (16),
    .DEPTH (Depth)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // clipping must keep every write inside the frame
  `RFB_ASSERT_IMP(a_write_in_frame, mem_we, mem_waddr <= AddrW'(Depth - 1), "frame write past end")
  // an idle sequencer never touches the frame memory
  `RFB_ASSERT_IMP(a_idle_no_write, in_ready_o, !mem_we, "frame write while idle")
  // a result beat only comes out of a read sequence
  `RFB_ASSERT_IMP(a_result_from_read, $rose(out_valid_o), !$past(in_ready_o), "result with no read")

endmodule
